// ===== rtl/scs_pkg.sv =====
`default_nettype none
package scs_pkg;
    localparam int unsigned POS_W = 8;
    localparam int unsigned TGT_W = 17;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [TGT_W-1:0] target;
    } t_req;

    typedef struct packed {
        logic [POS_W-1:0] low;
        logic [POS_W-1:0] high;
    } t_res;
endpackage
`default_nettype wire

// ===== rtl/scs_front.sv =====
`default_nettype none
// Front: latches requests into a two-entry queue; back pulls from it.
module scs_front (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_push,
    input  wire scs_pkg::t_req i_req,
    output logic           o_full,
    output logic           o_valid,
    output scs_pkg::t_req  o_req,
    input  wire            i_take
);
    import scs_pkg::*;

    t_req       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_take;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_req   = r_q[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_take  = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= i_req;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= !r_wp;
            if (w_take) r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_take};
        end
    end
endmodule
`default_nettype wire

// ===== rtl/scs_back.sv =====
`default_nettype none
// Back: walks (low, high) pairs (a near fit ends a low's highs early), one restoring-divide bit per cycle.
module scs_back #(
    parameter int unsigned SLIDER_STEPS = 256,
    parameter int unsigned FRAC_BITS    = 16
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_valid,
    input  wire scs_pkg::t_req i_req,
    output logic           o_take,
    output logic           o_res_valid,
    output scs_pkg::t_res  o_res,
    input  wire            i_res_pop
);
    import scs_pkg::*;

    localparam int unsigned PW  = $clog2(SLIDER_STEPS + 1);
    localparam int unsigned RW  = FRAC_BITS + 1;
    localparam int unsigned NW  = PW + FRAC_BITS;
    localparam int unsigned CW  = $clog2(NW + 1);
    localparam int unsigned DW  = (RW > TGT_W ? RW : TGT_W) + 1;
    localparam logic [DW-1:0] FULL = DW'(1) << FRAC_BITS;
    localparam logic [DW-1:0] NEAR = DW'(1) << (FRAC_BITS - 8);
    localparam logic [PW:0]   STEPS = (PW+1)'(SLIDER_STEPS);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_EVAL = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state          r_st;
    logic [PW:0]     r_pos, r_low, r_high;
    logic [DW-1:0]   r_tgt, r_best;
    logic [POS_W-1:0] r_blo, r_bhi;
    logic [NW-1:0]   r_num;
    logic [PW:0]     r_rem;
    logic [NW-1:0]   r_quo;
    logic [CW-1:0]   r_cnt;
    logic [PW:0]     w_span;
    logic [PW+1:0]   w_trial;
    logic [DW-1:0]   w_ratio, w_d;
    logic            w_fit, w_last_hi, w_stop, w_done;

    assign w_span  = r_high - r_low;
    assign w_trial = {r_rem, r_num[NW-1]};
    assign o_take  = (r_st == S_IDLE) && i_valid;
    assign o_res_valid = (r_st == S_OUT);
    assign o_res   = '{low: r_blo, high: r_bhi};

    always_comb begin
        if (w_span == '0) begin
            w_ratio = '0;
        end else if (DW'(r_quo) + NEAR >= FULL) begin
            w_ratio = FULL;
        end else begin
            w_ratio = DW'(r_quo);
        end
        w_d   = r_tgt - w_ratio;
        w_fit = (w_ratio <= r_tgt) && (w_d <= r_best);
        w_stop    = w_fit && (w_d < NEAR);
        w_last_hi = (r_high + 1'b1 >= STEPS) || w_stop;
        w_done    = w_last_hi && (r_low + 1'b1 >= r_pos);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
        end else begin
            case (r_st)
                S_IDLE: begin
                    if (i_valid) begin
                        r_pos  <= (PW+1)'(i_req.pos);
                        r_tgt  <= DW'(i_req.target);
                        r_best <= FULL;
                        r_blo  <= '1;
                        r_bhi  <= '0;
                        r_low  <= '0;
                        r_high <= (PW+1)'(i_req.pos);
                        r_num  <= NW'(i_req.pos) << FRAC_BITS;
                        r_rem  <= '0;
                        r_quo  <= '0;
                        r_cnt  <= '0;
                        if (i_req.pos == '0 || (PW+1)'(i_req.pos) >= STEPS) begin
                            r_st <= S_OUT;
                        end else begin
                            r_st <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (w_trial >= {1'b0, w_span} && w_span != '0) begin
                        r_rem <= (PW+1)'(w_trial - {1'b0, w_span});
                        r_quo <= {r_quo[NW-2:0], 1'b1};
                    end else begin
                        r_rem <= w_trial[PW:0];
                        r_quo <= {r_quo[NW-2:0], 1'b0};
                    end
                    r_num <= r_num << 1;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CW'(NW - 1)) r_st <= S_EVAL;
                end
                S_EVAL: begin
                    if (w_fit) begin
                        r_best <= w_d;
                        r_blo  <= r_low[POS_W-1:0];
                        r_bhi  <= r_high[POS_W-1:0];
                    end
                    if (w_done) begin
                        r_st <= S_OUT;
                    end else begin
                        if (w_last_hi) begin
                            r_low  <= r_low + 1'b1;
                            r_high <= r_pos;
                            r_num  <= NW'(r_pos - r_low - 1'b1) << FRAC_BITS;
                        end else begin
                            r_high <= r_high + 1'b1;
                            r_num  <= NW'(r_pos - r_low) << FRAC_BITS;
                        end
                        r_rem <= '0;
                        r_quo <= '0;
                        r_cnt <= '0;
                        r_st  <= S_DIV;
                    end
                end
                S_OUT: begin
                    if (i_res_pop) r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== rtl/slider_calibration_search.sv =====
`default_nettype none
// channel  | ports                          | handshake
// request  | i_slider_pos, i_target_level   | i_push / o_full
// result   | o_cal_low, o_cal_high          | o_empty / i_pop
// Each (low, high) pair is run through the one-bit-per-cycle restoring divider
// in the back end; a request takes up to pos*(SLIDER_STEPS-pos) pairs.
// Two requests queue in front.
// Synchronous active-low reset empties both sides. Result holds until popped.
module slider_calibration_search #(
    parameter int unsigned SLIDER_STEPS = 256,
    parameter int unsigned FRAC_BITS    = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_push,
    output logic        o_full,
    input  wire  [7:0]  i_slider_pos,
    input  wire  [16:0] i_target_level,
    output logic        o_empty,
    input  wire         i_pop,
    output logic [7:0]  o_cal_low,
    output logic [7:0]  o_cal_high
);
    import scs_pkg::*;

    t_req w_in, w_q;
    t_res w_res;
    logic w_valid, w_take, w_rv;

    assign w_in = '{pos: i_slider_pos, target: i_target_level};

    scs_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(i_push), .i_req(w_in),
        .o_full(o_full), .o_valid(w_valid), .o_req(w_q), .i_take(w_take)
    );

    scs_back #(.SLIDER_STEPS(SLIDER_STEPS), .FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_valid), .i_req(w_q),
        .o_take(w_take), .o_res_valid(w_rv), .o_res(w_res), .i_res_pop(i_pop)
    );

    assign o_empty    = !w_rv;
    assign o_cal_low  = w_res.low;
    assign o_cal_high = w_res.high;
endmodule
`default_nettype wire
